>>> sv/anwt_pkg.sv
// shared types, constants and helpers for the aging neighbor table
// no dependencies

package anwt_pkg;

  localparam int TABLE_SLOTS = 128;
  localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = IDX_W + 1;
  localparam int IN_W        = 72;
  localparam int OUT_W       = 88;

  localparam logic [31:0] TIMEOUT_RESET = 32'd28800;

  localparam logic [1:0] OUTCOME_NONE    = 2'd0;
  localparam logic [1:0] OUTCOME_KNOWN   = 2'd1;
  localparam logic [1:0] OUTCOME_EMPTY   = 2'd2;
  localparam logic [1:0] OUTCOME_EVICTED = 2'd3;

  typedef struct packed {
    logic [15:0] obs;
    logic [31:0] fh;
    logic [15:0] id;
  } entry_t;

  typedef struct packed {
    logic id_match;
    logic id_zero;
    logic older;
    logic expired;
  } cmp_flags_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

>>> sv/aging_neighbor_table_with_counts.sv
// aging neighbor table with saturating light/dark counts, top level
// a word with a message gets a scan pass, a message step and an aging pass, one without
// only the aging pass; each pass walks the table read port through one compare unit
// one entry at a time; no new word until idle; uses anwt_pkg, anwt_table, anwt_cmp
// synchronous active-low reset empties the table, clears counts, timeout 28800

module aging_neighbor_table_with_counts
  import anwt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // now_tick, msg_valid, sender_id, sender_value, sender_obs_index,
  // own_valid, own_value, zero pad
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  // light_total, dark_total, outcome, slot_used, value_counted,
  // pruned_total, zero pad
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_MSG  = 3'd2;
  localparam logic [2:0] ST_AGE  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             dv_r;
  logic [IDX_W-1:0] idx_r;
  logic [31:0]      timeout_r;
  logic [31:0]      light_r, dark_r;

  logic [31:0]      now_r;
  logic             msg_r;
  logic [15:0]      sid_r;
  logic             sval_r;
  logic [15:0]      sobs_r;

  logic             found_r;
  logic [IDX_W-1:0] hit_r;
  logic             empty_r;
  logic [IDX_W-1:0] free_r;
  logic [15:0]      free_obs_r;
  logic [IDX_W-1:0] old_r;
  logic [31:0]      old_fh_r;
  logic [15:0]      old_obs_r;

  logic [1:0]       outcome_r;
  logic [7:0]       slot_r;
  logic             counted_r;
  logic [8:0]       pruned_r;
  logic [OUT_W-1:0] out_tdata_r;
  logic             out_tvalid_r;

  logic             tbl_wr_en;
  logic [IDX_W-1:0] tbl_wr_addr;
  entry_t           tbl_wr_data;
  logic             tbl_rd_en;
  entry_t           tbl_rd_data;
  cmp_flags_t       flags;

  logic             accept;
  logic             scanning;
  logic             last_word;
  logic             out_free;
  logic [IDX_W-1:0] pick;
  logic [15:0]      pick_obs;
  logic             msg_count;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign scanning  = (state_r == ST_SCAN) || (state_r == ST_AGE);
  assign last_word = dv_r && (idx_r == IDX_LAST);
  assign out_free  = !out_tvalid_r || out_tready;
  assign tbl_rd_en = scanning && (cnt_r != CNT_END);

  assign pick      = empty_r ? free_r : old_r;
  assign pick_obs  = empty_r ? free_obs_r : old_obs_r;
  assign msg_count = (state_r == ST_MSG) && msg_r && !found_r && (pick_obs != sobs_r);

  anwt_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (cnt_r[IDX_W-1:0]),
    .rd_data (tbl_rd_data)
  );

  anwt_cmp u_cmp (
    .entry         (tbl_rd_data),
    .sender_id     (sid_r),
    .best_fh       (old_fh_r),
    .now_tick      (now_r),
    .timeout_ticks (timeout_r),
    .flags         (flags)
  );

  always_comb begin
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = pick;
    tbl_wr_data = '{obs: sobs_r, fh: now_r, id: sid_r};
    if ((state_r == ST_MSG) && msg_r && !found_r) begin
      tbl_wr_en = 1'b1;
    end else if ((state_r == ST_AGE) && dv_r && flags.expired) begin
      tbl_wr_en   = 1'b1;
      tbl_wr_addr = idx_r;
      tbl_wr_data = '{obs: tbl_rd_data.obs, fh: tbl_rd_data.fh, id: 16'd0};
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = in_tdata[32] ? ST_SCAN : ST_AGE;
        end
      end
      ST_SCAN: begin
        if (last_word) begin
          state_nxt = ST_MSG;
        end
      end
      ST_MSG: begin
        state_nxt = ST_AGE;
      end
      ST_AGE: begin
        if (last_word) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      dv_r         <= 1'b0;
      timeout_r    <= TIMEOUT_RESET;
      light_r      <= '0;
      dark_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (scanning && (state_nxt == state_r)) begin
        dv_r <= tbl_rd_en;
        if (tbl_rd_en) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end else begin
        dv_r  <= 1'b0;
        cnt_r <= '0;
      end
      if (accept && in_tdata[66]) begin
        if (in_tdata[67]) begin
          light_r <= sat_inc(light_r);
        end else begin
          dark_r <= sat_inc(dark_r);
        end
      end else if (msg_count) begin
        if (sval_r) begin
          light_r <= sat_inc(light_r);
        end else begin
          dark_r <= sat_inc(dark_r);
        end
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // per-word datapath
  always_ff @(posedge clk) begin
    idx_r <= cnt_r[IDX_W-1:0];
    if (accept) begin
      now_r     <= in_tdata[31:0];
      msg_r     <= in_tdata[32];
      sid_r     <= in_tdata[48:33];
      sval_r    <= in_tdata[49];
      sobs_r    <= in_tdata[65:50];
      found_r   <= 1'b0;
      empty_r   <= 1'b0;
      outcome_r <= OUTCOME_NONE;
      slot_r    <= '0;
      counted_r <= 1'b0;
      pruned_r  <= '0;
    end
    if ((state_r == ST_SCAN) && dv_r) begin
      if (flags.id_match) begin
        found_r <= 1'b1;
        hit_r   <= idx_r;
      end
      if (flags.id_zero && !empty_r) begin
        empty_r    <= 1'b1;
        free_r     <= idx_r;
        free_obs_r <= tbl_rd_data.obs;
      end
      if ((idx_r == '0) || flags.older) begin
        old_r     <= idx_r;
        old_fh_r  <= tbl_rd_data.fh;
        old_obs_r <= tbl_rd_data.obs;
      end
    end
    if (state_r == ST_MSG) begin
      if (found_r) begin
        outcome_r <= OUTCOME_KNOWN;
        slot_r    <= 8'(hit_r);
      end else begin
        outcome_r <= empty_r ? OUTCOME_EMPTY : OUTCOME_EVICTED;
        slot_r    <= 8'(pick);
        counted_r <= msg_count;
      end
    end
    if ((state_r == ST_AGE) && dv_r && flags.expired && !flags.id_zero) begin
      pruned_r <= pruned_r + 9'd1;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_tdata_r <= {4'd0, pruned_r, counted_r, slot_r, outcome_r, dark_r, light_r};
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

endmodule

>>> sv/anwt_table.sv
// neighbor table storage: one write port, one registered read port
// per-entry valid bits, an entry never written reads as zero; uses anwt_pkg

module anwt_table
  import anwt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t                 mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] valid_r;
  entry_t                 rd_q_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

>>> sv/anwt_cmp.sv
// shared compare unit applied to one table entry per cycle
// id match, empty, oldest and 33-bit timeout checks; uses anwt_pkg

module anwt_cmp
  import anwt_pkg::*;
(
  input  entry_t      entry,
  input  logic [15:0] sender_id,
  input  logic [31:0] best_fh,
  input  logic [31:0] now_tick,
  input  logic [31:0] timeout_ticks,
  output cmp_flags_t  flags
);

  logic [32:0] limit;

  assign limit = {1'b0, entry.fh} + {1'b0, timeout_ticks};

  always_comb begin
    flags.id_match = (entry.id == sender_id);
    flags.id_zero  = (entry.id == 16'd0);
    flags.older    = (entry.fh < best_fh);
    flags.expired  = ({1'b0, now_tick} > limit);
  end

endmodule
